/* hdl/assert_macros.svh */
// Assertion macros shared by the maze backtracker RTL.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/mzb_pkg.sv */
// Package for the maze backtracker: request and result structs, command codes,
// directions, status codes and build phases. No dependencies.
package mzb_pkg;

  localparam int COLUMN_W = 6;
  localparam int ROW_W    = 5;
  localparam int POS_X_W  = 6;
  localparam int POS_Y_W  = 5;
  localparam int DEPTH_W  = 10;

  typedef enum logic [1:0] {
    FUNC_START,
    FUNC_STEP,
    FUNC_OPEN,
    FUNC_READ
  } func_t;

  typedef enum logic [1:0] {
    DIR_EAST,
    DIR_NORTH,
    DIR_WEST,
    DIR_SOUTH
  } dir_t;

  typedef enum logic [2:0] {
    STAT_CARVED,
    STAT_REJECTED,
    STAT_BACKTRACK,
    STAT_STARTED,
    STAT_OPENED,
    STAT_OPEN_REJ,
    STAT_READ,
    STAT_WRONG_PHASE
  } status_t;

  typedef enum logic [1:0] {
    PH_CARVE,
    PH_NEED_EXIT,
    PH_NEED_ENTRY,
    PH_COMPLETE
  } phase_t;

  typedef struct packed {
    func_t               func;
    dir_t                choice;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic                cell_is_path;
    logic [POS_X_W-1:0]  pos_x;
    logic [POS_Y_W-1:0]  pos_y;
    logic [DEPTH_W-1:0]  depth;
    phase_t              phase;
  } rsp_t;

endpackage

/* hdl/mzb_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module mzb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

/* hdl/mzb_cell_unit.sv */
// Shared cell unit: picks one bit out of a grid row and forms the row with that bit set.
// No dependencies; columns at or beyond the row width read as wall and set nothing.
module mzb_cell_unit #(
  parameter int ROW_BITS = 63,
  parameter int COL_W    = 7
) (
  input  logic [ROW_BITS-1:0] row_word,
  input  logic [COL_W-1:0]    col,
  output logic                bit_o,
  output logic [ROW_BITS-1:0] row_set
);

  localparam int IW = $clog2(ROW_BITS);

  logic hit;

  assign hit     = col < COL_W'(ROW_BITS);
  assign bit_o   = hit ? row_word[col[IW-1:0]] : 1'b0;
  assign row_set = hit ? (row_word | (ROW_BITS'(1) << col[IW-1:0])) : row_word;

endmodule

/* hdl/maze_generator_backtracker_unit.sv */
// Maze generator by randomized depth-first carving with a position stack in RAM.
// Depends on mzb_pkg, mzb_ram, mzb_cell_unit and assert_macros.svh.
//
// The grid is held one row per RAM word and every cell access goes through the single
// grid port and one shared bit select unit. After reset the grid is wiped one row per
// cycle, and requests stall until the wipe is done; a start request does the same wipe
// and then registers its result. A carve step probes eight cells through the grid port,
// decides, does three read-modify-write passes and pushes before its result is
// registered; a rejected choice ends at the decision, a backtrack at the decision or
// after a stack read, an opening after its grid reads and the set, and a cell read after
// its row read. The next request is accepted once the result is registered, while that
// result may still wait in the output register; a new result waits until the one before
// it is taken, and requests stall meanwhile.
`include "assert_macros.svh"

module maze_generator_backtracker_unit import mzb_pkg::*; #(
  parameter int MAZE_WIDTH  = 63,
  parameter int MAZE_HEIGHT = 31,
  parameter int STACK_DEPTH = 512
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_rsp
);

  localparam int XW   = $clog2(MAZE_WIDTH);
  localparam int CW   = XW + 1;
  localparam int YW   = $clog2(MAZE_HEIGHT);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int CMPW = (CW > COLUMN_W) ? CW : COLUMN_W;
  localparam int RMW  = (YW + 1 > ROW_W) ? YW + 1 : ROW_W;

  localparam logic [XW-1:0]  X_EAST_LIM     = XW'(MAZE_WIDTH - 3);
  localparam logic [YW-1:0]  Y_SOUTH_LIM    = YW'(MAZE_HEIGHT - 3);
  localparam logic [YW-1:0]  ROW_LAST       = YW'(MAZE_HEIGHT - 1);
  localparam logic [YW-1:0]  ROW_INNER_LAST = YW'(MAZE_HEIGHT - 2);
  localparam logic [YW-1:0]  ROW_ONE        = YW'(1);
  localparam logic [SPW-1:0] SP_FULL        = SPW'(STACK_DEPTH);

  localparam logic [2:0] PRB_E1 = 3'd0;
  localparam logic [2:0] PRB_E2 = 3'd1;
  localparam logic [2:0] PRB_W1 = 3'd2;
  localparam logic [2:0] PRB_W2 = 3'd3;
  localparam logic [2:0] PRB_N1 = 3'd4;
  localparam logic [2:0] PRB_N2 = 3'd5;
  localparam logic [2:0] PRB_S1 = 3'd6;
  localparam logic [2:0] PRB_S2 = 3'd7;
  localparam logic [3:0] PROBE_CNT = 4'd8;
  localparam logic [1:0] CARVE_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DECIDE,
    S_POP_RD,
    S_CARVE_RD,
    S_CARVE_WR,
    S_PUSH,
    S_OPEN_RD,
    S_OPEN_CHK,
    S_OPEN_SET,
    S_READ_RD,
    S_READ_GET,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [YW-1:0]     clr_row_r;
  logic              start_r;
  logic [SPW-1:0]    sp_r;
  phase_t            phase_r;
  logic [XW-1:0]     tos_x_r;
  logic [YW-1:0]     tos_y_r;
  dir_t              choice_r;
  logic [CW-1:0]     col_r;
  logic [YW-1:0]     row_r;
  logic [3:0]        k_r;
  logic [7:0]        wall_r;
  logic [1:0]        a_r;
  status_t           status_r;
  logic              cell_r;
  logic              out_valid_r;
  rsp_t              out_rsp_r;

  logic              grid_we;
  logic [YW-1:0]     grid_addr;
  logic [MAZE_WIDTH-1:0] grid_wdata;
  logic [MAZE_WIDTH-1:0] grid_rdata;
  logic              stk_we;
  logic [SAW-1:0]    stk_addr;
  logic [XW+YW-1:0]  stk_wdata;
  logic [XW+YW-1:0]  stk_rdata;
  logic [CW-1:0]     unit_col;
  logic              unit_bit;
  logic [MAZE_WIDTH-1:0] unit_row_set;

  logic              ok_e;
  logic              ok_n;
  logic              ok_w;
  logic              ok_s;
  logic [3:0]        legal;
  logic              any_legal;
  logic [3:0]        k_prev;
  logic [CW-1:0]     carve_col;
  logic [YW-1:0]     carve_row;
  logic [YW-1:0]     open_row;
  logic              col_ok;
  logic              col_open_ok;
  logic              row_ok;

  function automatic logic [YW-1:0] probe_row_f(input logic [2:0] idx,
                                                input logic [YW-1:0] y,
                                                input logic n_ok,
                                                input logic s_ok);
    logic [YW-1:0] r;
    r = y;
    case (idx)
      PRB_N1: if (n_ok) r = y - YW'(1);
      PRB_N2: if (n_ok) r = y - YW'(2);
      PRB_S1: if (s_ok) r = y + YW'(1);
      PRB_S2: if (s_ok) r = y + YW'(2);
      default: r = y;
    endcase
    return r;
  endfunction

  function automatic logic [CW-1:0] probe_col_f(input logic [2:0] idx,
                                                input logic [XW-1:0] x);
    logic [CW-1:0] c;
    c = CW'(x);
    case (idx)
      PRB_E1: c = CW'(x) + CW'(1);
      PRB_E2: c = CW'(x) + CW'(2);
      PRB_W1: c = CW'(x) - CW'(1);
      PRB_W2: c = CW'(x) - CW'(2);
      default: c = CW'(x);
    endcase
    return c;
  endfunction

  mzb_ram #(
    .WIDTH (MAZE_WIDTH),
    .DEPTH (MAZE_HEIGHT)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_we),
    .addr  (grid_addr),
    .wdata (grid_wdata),
    .rdata (grid_rdata)
  );

  mzb_ram #(
    .WIDTH (XW + YW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  mzb_cell_unit #(
    .ROW_BITS (MAZE_WIDTH),
    .COL_W    (CW)
  ) u_cell_unit (
    .row_word (grid_rdata),
    .col      (unit_col),
    .bit_o    (unit_bit),
    .row_set  (unit_row_set)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign ok_e = tos_x_r < X_EAST_LIM;
  assign ok_n = tos_y_r > YW'(2);
  assign ok_w = tos_x_r > XW'(2);
  assign ok_s = tos_y_r < Y_SOUTH_LIM;

  assign legal[DIR_EAST]  = ok_e & wall_r[PRB_E1] & wall_r[PRB_E2];
  assign legal[DIR_NORTH] = ok_n & wall_r[PRB_N1] & wall_r[PRB_N2];
  assign legal[DIR_WEST]  = ok_w & wall_r[PRB_W1] & wall_r[PRB_W2];
  assign legal[DIR_SOUTH] = ok_s & wall_r[PRB_S1] & wall_r[PRB_S2];
  assign any_legal = (sp_r < SP_FULL) && (legal != 4'b0000);

  assign k_prev   = k_r - 4'd1;
  assign open_row = (phase_r == PH_NEED_EXIT) ? ROW_LAST : '0;

  assign col_ok      = CMPW'(in_req.column) < CMPW'(MAZE_WIDTH);
  assign col_open_ok = CMPW'(in_req.column) < CMPW'(MAZE_WIDTH - 1);
  assign row_ok      = RMW'(in_req.row) < RMW'(MAZE_HEIGHT);

  always_comb begin
    carve_col = CW'(tos_x_r);
    carve_row = tos_y_r;
    case (choice_r)
      DIR_EAST:  carve_col = CW'(tos_x_r) + CW'(a_r);
      DIR_NORTH: carve_row = tos_y_r - YW'(a_r);
      DIR_WEST:  carve_col = CW'(tos_x_r) - CW'(a_r);
      DIR_SOUTH: carve_row = tos_y_r + YW'(a_r);
      default: ;
    endcase
  end

  always_comb begin
    grid_we    = 1'b0;
    grid_addr  = tos_y_r;
    grid_wdata = unit_row_set;
    unit_col   = col_r;
    unique case (state_r)
      S_CLEAR: begin
        grid_we    = 1'b1;
        grid_addr  = clr_row_r;
        grid_wdata = '0;
      end
      S_PROBE: begin
        grid_addr = probe_row_f(k_r[2:0], tos_y_r, ok_n, ok_s);
        unit_col  = probe_col_f(k_prev[2:0], tos_x_r);
      end
      S_CARVE_RD: grid_addr = carve_row;
      S_CARVE_WR: begin
        grid_we   = 1'b1;
        grid_addr = carve_row;
        unit_col  = carve_col;
      end
      S_OPEN_RD:  grid_addr = (phase_r == PH_NEED_EXIT) ? ROW_INNER_LAST : ROW_ONE;
      S_OPEN_CHK: grid_addr = open_row;
      S_OPEN_SET: begin
        grid_we   = 1'b1;
        grid_addr = open_row;
      end
      S_READ_RD:  grid_addr = row_r;
      default: ;
    endcase
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_addr  = SAW'(sp_r - SPW'(2));
    stk_wdata = {XW'(carve_col), carve_row};
    unique case (state_r)
      S_CLEAR: begin
        stk_we    = start_r;
        stk_addr  = '0;
        stk_wdata = {XW'(1), YW'(1)};
      end
      S_PUSH: begin
        stk_we   = 1'b1;
        stk_addr = SAW'(sp_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      start_r     <= 1'b0;
      sp_r        <= '0;
      phase_r     <= PH_COMPLETE;
      k_r         <= '0;
      a_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (clr_row_r == ROW_LAST) begin
            clr_row_r <= '0;
            if (start_r) begin
              start_r  <= 1'b0;
              sp_r     <= SPW'(1);
              tos_x_r  <= XW'(1);
              tos_y_r  <= YW'(1);
              phase_r  <= PH_CARVE;
              status_r <= STAT_STARTED;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            clr_row_r <= clr_row_r + YW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            choice_r <= in_req.choice;
            col_r    <= CW'(in_req.column);
            row_r    <= YW'(in_req.row);
            cell_r   <= 1'b0;
            unique case (in_req.func)
              FUNC_START: begin
                start_r <= 1'b1;
                state_r <= S_CLEAR;
              end
              FUNC_STEP: begin
                if (phase_r != PH_CARVE || sp_r == '0) begin
                  status_r <= STAT_WRONG_PHASE;
                  state_r  <= S_DONE;
                end else begin
                  k_r     <= '0;
                  state_r <= S_PROBE;
                end
              end
              FUNC_OPEN: begin
                if (!(phase_r == PH_NEED_EXIT || phase_r == PH_NEED_ENTRY)) begin
                  status_r <= STAT_WRONG_PHASE;
                  state_r  <= S_DONE;
                end else if (!col_open_ok) begin
                  status_r <= STAT_OPEN_REJ;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_OPEN_RD;
                end
              end
              FUNC_READ: begin
                if (row_ok && col_ok) begin
                  state_r <= S_READ_RD;
                end else begin
                  status_r <= STAT_READ;
                  state_r  <= S_DONE;
                end
              end
            endcase
          end
        end
        S_PROBE: begin
          if (k_r != '0) begin
            wall_r[k_prev[2:0]] <= !unit_bit;
          end
          if (k_r == PROBE_CNT) begin
            state_r <= S_DECIDE;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_DECIDE: begin
          if (!any_legal) begin
            sp_r     <= sp_r - SPW'(1);
            status_r <= STAT_BACKTRACK;
            if (sp_r == SPW'(1)) begin
              phase_r <= PH_NEED_EXIT;
              state_r <= S_DONE;
            end else begin
              state_r <= S_POP_RD;
            end
          end else if (!legal[choice_r]) begin
            status_r <= STAT_REJECTED;
            state_r  <= S_DONE;
          end else begin
            a_r     <= '0;
            state_r <= S_CARVE_RD;
          end
        end
        S_POP_RD: begin
          tos_x_r <= stk_rdata[XW+YW-1:YW];
          tos_y_r <= stk_rdata[YW-1:0];
          state_r <= S_DONE;
        end
        S_CARVE_RD: state_r <= S_CARVE_WR;
        S_CARVE_WR: begin
          if (a_r == CARVE_LAST) begin
            state_r <= S_PUSH;
          end else begin
            a_r     <= a_r + 2'd1;
            state_r <= S_CARVE_RD;
          end
        end
        S_PUSH: begin
          sp_r     <= sp_r + SPW'(1);
          tos_x_r  <= XW'(carve_col);
          tos_y_r  <= carve_row;
          status_r <= STAT_CARVED;
          state_r  <= S_DONE;
        end
        S_OPEN_RD: state_r <= S_OPEN_CHK;
        S_OPEN_CHK: begin
          if (!unit_bit) begin
            status_r <= STAT_OPEN_REJ;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_OPEN_SET;
          end
        end
        S_OPEN_SET: begin
          phase_r  <= (phase_r == PH_NEED_EXIT) ? PH_NEED_ENTRY : PH_COMPLETE;
          status_r <= STAT_OPENED;
          state_r  <= S_DONE;
        end
        S_READ_RD: state_r <= S_READ_GET;
        S_READ_GET: begin
          cell_r   <= unit_bit;
          status_r <= STAT_READ;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r            <= 1'b1;
            out_rsp_r.status       <= status_r;
            out_rsp_r.cell_is_path <= cell_r;
            out_rsp_r.pos_x        <= (sp_r != '0) ? POS_X_W'(tos_x_r) : '0;
            out_rsp_r.pos_y        <= (sp_r != '0) ? POS_Y_W'(tos_y_r) : '0;
            out_rsp_r.depth        <= DEPTH_W'(sp_r);
            out_rsp_r.phase        <= phase_r;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_PROP(a_carve_has_stack, clk, rst_n, (phase_r == PH_CARVE) |-> (sp_r != '0), "carving with empty stack")
  `ASSERT_PROP(a_push_in_bounds, clk, rst_n, (state_r == S_PUSH) |-> (sp_r < SP_FULL), "push on full stack")
  `ASSERT_NEXT(a_push_grows, clk, rst_n, state_r == S_PUSH, sp_r == $past(sp_r) + 1'b1, "push lost")
  `ASSERT_NEXT(a_done_sends, clk, rst_n, state_r == S_DONE && !(out_valid_r && out_stall), out_valid_r, "result dropped")

endmodule

/* verif/mzb_carve_monitor.sv */
`timescale 1ns / 1ps
// Result monitor for the maze backtracker testbench: keeps its own grid, position stack
// and build phase, predicts a result per accepted request and checks the results in order.
// Depends on mzb_pkg.
module mzb_carve_monitor import mzb_pkg::*; #(
  parameter int MAZE_WIDTH  = 63,
  parameter int MAZE_HEIGHT = 31,
  parameter int STACK_DEPTH = 512
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  req_t in_req,
  input  logic out_valid,
  input  logic out_stall,
  input  rsp_t out_rsp,
  output int   fail_count,
  output int   awaited_count
);

  bit               cell_open [MAZE_HEIGHT][MAZE_WIDTH];
  bit [POS_X_W-1:0] trail_x [STACK_DEPTH];
  bit [POS_Y_W-1:0] trail_y [STACK_DEPTH];
  int               trail_len = 0;
  phase_t           build_phase = PH_COMPLETE;
  rsp_t             awaited_results [$];
  rsp_t             oldest;
  int               n_fail = 0;
  int               n_awaited = 0;

  assign fail_count    = n_fail;
  assign awaited_count = n_awaited;

  function automatic bit move_open(int x, int y, dir_t d);
    if (x >= MAZE_WIDTH || y >= MAZE_HEIGHT) return 1'b0;
    case (d)
      DIR_EAST:  return x < MAZE_WIDTH - 3 && !cell_open[y][x+1] && !cell_open[y][x+2];
      DIR_NORTH: return y > 2 && !cell_open[y-1][x] && !cell_open[y-2][x];
      DIR_WEST:  return x > 2 && !cell_open[y][x-1] && !cell_open[y][x-2];
      default:   return y < MAZE_HEIGHT - 3 && !cell_open[y+1][x] && !cell_open[y+2][x];
    endcase
  endfunction

  function automatic status_t carve_step(dir_t d);
    int x;
    int y;
    int nx;
    int ny;
    bit any_move;
    if (build_phase != PH_CARVE || trail_len == 0) return STAT_WRONG_PHASE;
    x = trail_x[trail_len-1];
    y = trail_y[trail_len-1];
    any_move = 1'b0;
    // A full stack counts as a dead end.
    if (trail_len < STACK_DEPTH) begin
      for (int a = 0; a < 4; a++) begin
        if (move_open(x, y, dir_t'(a))) any_move = 1'b1;
      end
    end
    if (!any_move) begin
      trail_len--;
      if (trail_len == 0) build_phase = PH_NEED_EXIT;
      return STAT_BACKTRACK;
    end
    if (!move_open(x, y, d)) return STAT_REJECTED;
    nx = x;
    ny = y;
    for (int a = 0; a <= 2; a++) begin
      case (d)
        DIR_EAST:  nx = x + a;
        DIR_NORTH: ny = y - a;
        DIR_WEST:  nx = x - a;
        default:   ny = y + a;
      endcase
      cell_open[ny][nx] = 1'b1;
    end
    trail_x[trail_len] = POS_X_W'(nx);
    trail_y[trail_len] = POS_Y_W'(ny);
    trail_len++;
    return STAT_CARVED;
  endfunction

  function automatic status_t place_opening(int col);
    if (build_phase != PH_NEED_EXIT && build_phase != PH_NEED_ENTRY) return STAT_WRONG_PHASE;
    if (col >= MAZE_WIDTH - 1) return STAT_OPEN_REJ;
    if (build_phase == PH_NEED_EXIT) begin
      if (!cell_open[MAZE_HEIGHT-2][col]) return STAT_OPEN_REJ;
      cell_open[MAZE_HEIGHT-1][col] = 1'b1;
      build_phase = PH_NEED_ENTRY;
    end else begin
      if (!cell_open[1][col]) return STAT_OPEN_REJ;
      cell_open[0][col] = 1'b1;
      build_phase = PH_COMPLETE;
    end
    return STAT_OPENED;
  endfunction

  function automatic rsp_t next_maze_result(req_t r);
    rsp_t res;
    res = '0;
    case (r.func)
      FUNC_START: begin
        for (int yy = 0; yy < MAZE_HEIGHT; yy++) begin
          for (int xx = 0; xx < MAZE_WIDTH; xx++) cell_open[yy][xx] = 1'b0;
        end
        trail_x[0] = 1;
        trail_y[0] = 1;
        trail_len = 1;
        build_phase = PH_CARVE;
        res.status = STAT_STARTED;
      end
      FUNC_STEP: res.status = carve_step(r.choice);
      FUNC_OPEN: res.status = place_opening(int'(r.column));
      default: begin
        if (r.row < MAZE_HEIGHT && r.column < MAZE_WIDTH) begin
          res.cell_is_path = cell_open[r.row][r.column];
        end
        res.status = STAT_READ;
      end
    endcase
    if (trail_len > 0 && trail_len <= STACK_DEPTH) begin
      res.pos_x = trail_x[trail_len-1];
      res.pos_y = trail_y[trail_len-1];
    end
    res.depth = DEPTH_W'(trail_len);
    res.phase = build_phase;
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited: expected nothing, got %p", $time, out_rsp);
          n_fail++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", oldest.status, out_rsp.status);
          check_field("cell_is_path", oldest.cell_is_path, out_rsp.cell_is_path);
          check_field("pos_x", oldest.pos_x, out_rsp.pos_x);
          check_field("pos_y", oldest.pos_y, out_rsp.pos_y);
          check_field("depth", oldest.depth, out_rsp.depth);
          check_field("phase", oldest.phase, out_rsp.phase);
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(next_maze_result(in_req));
      n_awaited = awaited_results.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top of the maze backtracker testbench: clock, reset, request stimulus, result stalls
// and the verdict. Depends on mzb_pkg, maze_generator_backtracker_unit and mzb_carve_monitor.
module testbench;
  import mzb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  req_t   in_req;
  logic   out_valid;
  logic   out_stall;
  rsp_t   out_rsp;
  int     fail_count;
  int     awaited_count;
  int     idle_pct = 0;
  int     stall_pct = 0;
  bit     hold_off = 1'b0;
  int     cycle_count = 0;
  int     sent = 0;
  phase_t seen_phase = PH_COMPLETE;

  maze_generator_backtracker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  mzb_carve_monitor u_carve_mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rsp       (out_rsp),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) seen_phase <= out_rsp.phase;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic req_t build_req(func_t f, dir_t d, int col, int row);
    req_t r;
    r.func   = f;
    r.choice = d;
    r.column = COLUMN_W'(col);
    r.row    = ROW_W'(row);
    return r;
  endfunction

  task automatic send_req(req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
    if (sent % 128 == 0) begin
      case ((sent / 128) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
    end
    // Long receiver hold-off so the block fills up and stalls its requests.
    if (sent == 400) hold_off = 1'b1;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_count != 0);
  endtask

  task automatic random_carve_item;
    int pick;
    int top;
    dir_t d;
    pick = $urandom_range(0, 99);
    d = dir_t'($urandom_range(0, 3));
    top = u_carve_mon.trail_len - 1;
    // Most steps turn toward a direction that can still be carved, so one maze
    // finishes in about a thousand requests.
    if (top >= 0 && $urandom_range(0, 19) != 0) begin
      for (int a = 0; a < 4; a++) begin
        if (!u_carve_mon.move_open(int'(u_carve_mon.trail_x[top]),
                                   int'(u_carve_mon.trail_y[top]), d)) begin
          d = dir_t'(2'(int'(d) + 1));
        end
      end
    end
    if (pick < 3) begin
      send_req(build_req(FUNC_READ, d, $urandom_range(0, 63), $urandom_range(0, 31)));
    end else if (pick < 4) begin
      send_req(build_req(FUNC_OPEN, d, $urandom_range(0, 63), $urandom_range(0, 31)));
    end else begin
      send_req(build_req(FUNC_STEP, d, $urandom_range(0, 63), $urandom_range(0, 31)));
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    send_req(build_req(FUNC_READ, DIR_EAST, 0, 0));
    send_req(build_req(FUNC_STEP, DIR_SOUTH, 0, 0));
    send_req(build_req(FUNC_OPEN, DIR_EAST, 5, 0));
    send_req(build_req(FUNC_START, DIR_WEST, 63, 31));
    send_req(build_req(FUNC_STEP, DIR_WEST, 0, 0));
    send_req(build_req(FUNC_STEP, DIR_NORTH, 0, 0));
    send_req(build_req(FUNC_STEP, DIR_EAST, 0, 0));
    send_req(build_req(FUNC_STEP, DIR_SOUTH, 0, 0));
    send_req(build_req(FUNC_READ, DIR_EAST, 2, 1));
    send_req(build_req(FUNC_READ, DIR_EAST, 0, 31));
    send_req(build_req(FUNC_READ, DIR_EAST, 63, 30));
    send_req(build_req(FUNC_READ, DIR_EAST, 62, 30));
    send_req(build_req(FUNC_READ, DIR_EAST, 3, 3));
    send_req(build_req(FUNC_OPEN, DIR_EAST, 0, 0));
    send_req(build_req(FUNC_START, DIR_EAST, 0, 0));
    send_req(build_req(FUNC_READ, DIR_EAST, 2, 1));
    send_req(build_req(FUNC_STEP, DIR_SOUTH, 0, 0));
    send_req(build_req(FUNC_STEP, DIR_NORTH, 0, 0));
    send_req(build_req(FUNC_STEP, DIR_EAST, 0, 0));

    send_req(build_req(FUNC_START, dir_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                       $urandom_range(0, 31)));
    drain();
    while (seen_phase == PH_CARVE) random_carve_item();
    drain();
    send_req(build_req(FUNC_OPEN, DIR_EAST, 0, 0));
    send_req(build_req(FUNC_OPEN, DIR_EAST, 62, 0));
    send_req(build_req(FUNC_OPEN, DIR_EAST, 63, 0));
    drain();
    while (seen_phase == PH_NEED_EXIT || seen_phase == PH_NEED_ENTRY) begin
      send_req(build_req(FUNC_OPEN, dir_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 31)));
      drain();
    end

    for (int i = 0; i < 10; i++) begin
      send_req(build_req(FUNC_READ, DIR_EAST, $urandom_range(0, 63), $urandom_range(0, 31)));
    end
    send_req(build_req(FUNC_STEP, DIR_EAST, 0, 0));
    send_req(build_req(FUNC_OPEN, DIR_EAST, 1, 0));
    drain();
    repeat (40) @(negedge clk);

    if (fail_count == 0 && awaited_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
